// ===== rtl/rc_differential_drive_mixer_defines.svh =====
// Assertion shorthands shared by the mixer RTL.
`ifndef RC_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define RC_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define RCDDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcddm: same-cycle check failed");

// Consequent checked at the next edge after the antecedent.
`define RCDDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcddm: next-cycle check failed");

`endif

// ===== rtl/rcddm_pkg.sv =====
package rcddm_pkg;

  // Defaults for the top level parameters
  localparam int unsigned MUTE_ITEMS_DEF   = 100;
  localparam int unsigned CHANNEL_BITS_DEF = 11;

  // Stick geometry
  localparam int unsigned CH_LOW  = 500;
  localparam int unsigned CH_HIGH = 1500;
  localparam int unsigned CH_MID  = 1000;

  // Shared multiplier operand width
  localparam int unsigned MUL_W = 32;

  // pi/2 in Q2.14
  localparam int unsigned HALF_PI_Q14 = 25736;

  // Turn divisor 8192000000 = 2^19 * 15625; the 15625 part goes by reciprocal
  localparam int unsigned TURN_DIV   = 15625;
  localparam int unsigned RECIP_TURN = 34359;  // floor(2^29 / 15625)

  // Forward divisor
  localparam int unsigned STICK_SPAN = 500;
  localparam int unsigned RECIP_SPAN = 16777;  // floor(2^23 / 500)

  // Register widths and reset values
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned BASE_VEL_RST = 500;
  localparam int unsigned DEADBAND_RST = 100;
  localparam int unsigned SPACING_RST  = 300;
  localparam int unsigned LIMIT_RST    = 3500;

  typedef enum logic [1:0] {
    REG_BASE_VELOCITY = 2'd0,
    REG_DEADBAND      = 2'd1,
    REG_WHEEL_SPACING = 2'd2,
    REG_SPEED_LIMIT   = 2'd3
  } reg_idx_t;

  // Sign and magnitude of one centred stick offset
  typedef struct packed {
    logic       neg;
    logic [8:0] mag;
  } stick_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_M1   = 11'b00000000010,  // |rot| * pi/2
    S_M2   = 11'b00000000100,  // speed * spacing
    S_M3   = 11'b00000001000,  // full turn product
    S_M4   = 11'b00000010000,  // turn estimate by reciprocal
    S_M5   = 11'b00000100000,  // estimate * divisor
    S_M6   = 11'b00001000000,  // turn correction, |fwd| * speed
    S_M7   = 11'b00010000000,  // forward estimate by reciprocal
    S_M8   = 11'b00100000000,  // estimate * span
    S_FCOR = 11'b01000000000,  // forward correction
    S_FIN  = 11'b10000000000   // combine, saturate, load output
  } state_t;

endpackage

// ===== rtl/rcddm_mul.sv =====
module rcddm_mul (
  input  logic                            clk,
  input  logic [rcddm_pkg::MUL_W-1:0]     a,
  input  logic [rcddm_pkg::MUL_W-1:0]     b,
  output logic [2*rcddm_pkg::MUL_W-1:0]   p_r
);

  always_ff @(posedge clk) begin
    p_r <= (2*rcddm_pkg::MUL_W)'(a) * (2*rcddm_pkg::MUL_W)'(b);
  end

endmodule

// ===== rtl/rc_differential_drive_mixer.sv =====
// Words step S_IDLE, S_M1..S_M8, S_FCOR, S_FIN (muted: S_IDLE, S_FIN); S_FIN
// loads the result, and no new word is taken until it fires. Every product,
// reciprocal divide and remainder check goes through one registered 32x32
// multiplier, one operation per cycle, eight operations per unmuted word.
// Reset (rst_n, synchronous, active low): registers to their defaults, mute
// count to MUTE_ITEMS, sequencer idle, output empty.
module rc_differential_drive_mixer #(
  parameter int unsigned MUTE_ITEMS   = rcddm_pkg::MUTE_ITEMS_DEF,
  parameter int unsigned CHANNEL_BITS = rcddm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [CHANNEL_BITS-1:0]             in_rotation_channel,
  input  logic [CHANNEL_BITS-1:0]             in_throttle_channel,
  input  logic [CHANNEL_BITS-1:0]             in_forward_channel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [13:0]                  out_left_target,
  output logic signed [13:0]                  out_right_target,
  output logic                                out_muted,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [rcddm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  `include "rc_differential_drive_mixer_defines.svh"

  localparam int unsigned MW = rcddm_pkg::MUL_W;

  rcddm_pkg::state_t state_r, state_nxt;

  logic [12:0] base_velocity_r;
  logic [8:0]  deadband_r;
  logic [10:0] wheel_spacing_r;
  logic [12:0] speed_limit_r;
  logic [7:0]  mute_remaining_r;

  logic        mute_item_r;
  logic [8:0]  rot_mag_r;
  logic        rot_pos_r;
  logic [8:0]  fwd_off_mag_r;
  logic        fwd_neg_r;
  logic [13:0] speed_r;
  logic [23:0] t1_r;
  logic [28:0] x_turn_r;
  logic [14:0] turn_mag_r;
  logic [22:0] x_fwd_r;
  logic [13:0] fwd_res_r;

  logic               out_valid_r;
  logic signed [13:0] out_left_r;
  logic signed [13:0] out_right_r;
  logic               out_muted_r;

  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod;

  rcddm_pkg::stick_t rot_in, thr_in, fwd_in;
  logic [13:0]       speed_in;
  logic              in_acc, fin_fire;
  logic [28:0]       turn_rem;
  logic [22:0]       fwd_rem;
  logic              fwd_is_neg, turn_neg;
  logic signed [16:0] fwd_s, turn_s, left_s, right_s, lim_s;
  logic signed [13:0] left_sat, right_sat;

  function automatic rcddm_pkg::stick_t stick_off(input logic [CHANNEL_BITS-1:0] raw,
                                                  input logic [8:0] db);
    logic [10:0]       v;
    rcddm_pkg::stick_t s;
    if (raw < CHANNEL_BITS'(rcddm_pkg::CH_LOW)) begin
      v = 11'(rcddm_pkg::CH_LOW);
    end else if (raw > CHANNEL_BITS'(rcddm_pkg::CH_HIGH)) begin
      v = 11'(rcddm_pkg::CH_HIGH);
    end else begin
      v = raw[10:0];
    end
    if (v >= 11'(rcddm_pkg::CH_MID)) begin
      s.neg = 1'b0;
      s.mag = 9'(v - 11'(rcddm_pkg::CH_MID));
    end else begin
      s.neg = 1'b1;
      s.mag = 9'(11'(rcddm_pkg::CH_MID) - v);
    end
    // inside the deadband: drop to zero
    if (s.mag < db) begin
      s.neg = 1'b0;
      s.mag = '0;
    end
    return s;
  endfunction

  function automatic logic signed [13:0] sat(input logic signed [16:0] v,
                                             input logic signed [16:0] lim);
    logic signed [16:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r[13:0];
  endfunction

  assign in_stall  = (state_r != rcddm_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign fin_fire  = (state_r == rcddm_pkg::S_FIN) && (!out_valid_r || !out_stall);

  assign rot_in = stick_off(in_rotation_channel, deadband_r);
  assign thr_in = stick_off(in_throttle_channel, deadband_r);
  assign fwd_in = stick_off(in_forward_channel, deadband_r);

  // speed = base + throttle offset, floored at zero
  always_comb begin
    if (thr_in.neg) begin
      speed_in = (base_velocity_r >= 13'(thr_in.mag)) ?
                 14'(base_velocity_r - 13'(thr_in.mag)) : 14'd0;
    end else begin
      speed_in = 14'(base_velocity_r) + 14'(thr_in.mag);
    end
  end

  rcddm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  always_comb begin
    unique case (state_r)
      rcddm_pkg::S_M1: begin
        mul_a = MW'(rot_mag_r);
        mul_b = MW'(rcddm_pkg::HALF_PI_Q14);
      end
      rcddm_pkg::S_M2: begin
        mul_a = MW'(speed_r);
        mul_b = MW'(wheel_spacing_r);
      end
      rcddm_pkg::S_M3: begin
        mul_a = MW'(t1_r);
        mul_b = MW'(prod[24:0]);
      end
      rcddm_pkg::S_M4: begin
        mul_a = MW'(prod[47:19]);
        mul_b = MW'(rcddm_pkg::RECIP_TURN);
      end
      rcddm_pkg::S_M5: begin
        mul_a = MW'(prod[43:29]);
        mul_b = MW'(rcddm_pkg::TURN_DIV);
      end
      rcddm_pkg::S_M6: begin
        mul_a = MW'(fwd_off_mag_r);
        mul_b = MW'(speed_r);
      end
      rcddm_pkg::S_M7: begin
        mul_a = MW'(prod[22:0]);
        mul_b = MW'(rcddm_pkg::RECIP_SPAN);
      end
      rcddm_pkg::S_M8: begin
        mul_a = MW'(prod[36:23]);
        mul_b = MW'(rcddm_pkg::STICK_SPAN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // remainders after the reciprocal estimates
  assign turn_rem = x_turn_r - prod[28:0];
  assign fwd_rem  = x_fwd_r - prod[22:0];

  // combine stage
  assign fwd_is_neg = fwd_neg_r && (fwd_res_r != 14'd0);
  assign turn_neg   = rot_pos_r ^ fwd_is_neg;
  assign fwd_s      = fwd_neg_r ? -$signed({3'b000, fwd_res_r}) : $signed({3'b000, fwd_res_r});
  assign turn_s     = turn_neg ? -$signed({2'b00, turn_mag_r}) : $signed({2'b00, turn_mag_r});
  assign left_s     = fwd_s - turn_s;
  assign right_s    = fwd_s + turn_s;
  assign lim_s      = $signed({4'b0000, speed_limit_r});
  assign left_sat   = sat(left_s, lim_s);
  assign right_sat  = sat(right_s, lim_s);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcddm_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (mute_remaining_r != 8'd0) ? rcddm_pkg::S_FIN : rcddm_pkg::S_M1;
        end
      end
      rcddm_pkg::S_M1:   state_nxt = rcddm_pkg::S_M2;
      rcddm_pkg::S_M2:   state_nxt = rcddm_pkg::S_M3;
      rcddm_pkg::S_M3:   state_nxt = rcddm_pkg::S_M4;
      rcddm_pkg::S_M4:   state_nxt = rcddm_pkg::S_M5;
      rcddm_pkg::S_M5:   state_nxt = rcddm_pkg::S_M6;
      rcddm_pkg::S_M6:   state_nxt = rcddm_pkg::S_M7;
      rcddm_pkg::S_M7:   state_nxt = rcddm_pkg::S_M8;
      rcddm_pkg::S_M8:   state_nxt = rcddm_pkg::S_FCOR;
      rcddm_pkg::S_FCOR: state_nxt = rcddm_pkg::S_FIN;
      rcddm_pkg::S_FIN: begin
        if (fin_fire) begin
          state_nxt = rcddm_pkg::S_IDLE;
        end
      end
      default:           state_nxt = rcddm_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= rcddm_pkg::S_IDLE;
      out_valid_r      <= 1'b0;
      mute_remaining_r <= 8'(MUTE_ITEMS);
      base_velocity_r  <= 13'(rcddm_pkg::BASE_VEL_RST);
      deadband_r       <= 9'(rcddm_pkg::DEADBAND_RST);
      wheel_spacing_r  <= 11'(rcddm_pkg::SPACING_RST);
      speed_limit_r    <= 13'(rcddm_pkg::LIMIT_RST);
    end else begin
      state_r <= state_nxt;
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && (mute_remaining_r != 8'd0)) begin
        mute_remaining_r <= mute_remaining_r - 8'd1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (rcddm_pkg::reg_idx_t'(cfg_index))
          rcddm_pkg::REG_BASE_VELOCITY: base_velocity_r <= cfg_data[12:0];
          rcddm_pkg::REG_DEADBAND:      deadband_r      <= cfg_data[8:0];
          rcddm_pkg::REG_WHEEL_SPACING: wheel_spacing_r <= cfg_data[10:0];
          rcddm_pkg::REG_SPEED_LIMIT:   speed_limit_r   <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mute_item_r   <= (mute_remaining_r != 8'd0);
      rot_mag_r     <= rot_in.mag;
      rot_pos_r     <= !rot_in.neg && (rot_in.mag != 9'd0);
      fwd_off_mag_r <= fwd_in.mag;
      fwd_neg_r     <= fwd_in.neg;
      speed_r       <= speed_in;
    end
    unique case (state_r)
      rcddm_pkg::S_M2: t1_r <= prod[23:0];
      rcddm_pkg::S_M4: x_turn_r <= prod[47:19];
      rcddm_pkg::S_M5: turn_mag_r <= prod[43:29];
      rcddm_pkg::S_M6: begin
        // estimate is low by at most one
        if (turn_rem >= 29'(rcddm_pkg::TURN_DIV)) begin
          turn_mag_r <= turn_mag_r + 15'd1;
        end
      end
      rcddm_pkg::S_M7: x_fwd_r <= prod[22:0];
      rcddm_pkg::S_M8: fwd_res_r <= prod[36:23];
      rcddm_pkg::S_FCOR: begin
        if (fwd_rem >= 23'(rcddm_pkg::STICK_SPAN)) begin
          fwd_res_r <= fwd_res_r + 14'd1;
        end
      end
      default: ;
    endcase
    if (fin_fire) begin
      out_muted_r <= mute_item_r;
      out_left_r  <= mute_item_r ? 14'sd0 : left_sat;
      out_right_r <= mute_item_r ? 14'sd0 : right_sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_target  = out_left_r;
  assign out_right_target = out_right_r;
  assign out_muted        = out_muted_r;

  `RCDDM_ASSERT_NEXT(a_mute_count, clk, rst_n,
    in_acc && (mute_remaining_r != 8'd0),
    mute_remaining_r == ($past(mute_remaining_r) - 8'd1))
  `RCDDM_ASSERT_NOW(a_left_limit, clk, rst_n, out_valid_r && !out_muted_r,
    ($signed(out_left_r) <= lim_s) && ($signed(out_left_r) >= -lim_s))
  `RCDDM_ASSERT_NOW(a_right_limit, clk, rst_n, out_valid_r && !out_muted_r,
    ($signed(out_right_r) <= lim_s) && ($signed(out_right_r) >= -lim_s))
  `RCDDM_ASSERT_NEXT(a_fin_hold, clk, rst_n,
    (state_r == rcddm_pkg::S_FIN) && out_valid_r && out_stall,
    state_r == rcddm_pkg::S_FIN)

endmodule
